### rtl/core/spifcs_pkg.sv
`timescale 1ns / 1ps

package spifcs_pkg;

  // Field widths
  localparam int ADDR_W = 24;
  localparam int BYTE_W = 8;

  // Page size of the device; must be a power of two
  localparam int PAGE_BYTES = 256;
  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

  // Descriptor queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_OP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_OP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WREN_OP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_OP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLK32_OP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLK64_OP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_OP    = 3'd6;

  // Request kinds on the input stream
  typedef enum logic [2:0] {
    REQ_READ         = 3'd0,
    REQ_PROGRAM      = 3'd1,
    REQ_SECTOR_ERASE = 3'd2,
    REQ_BLK32_ERASE  = 3'd3,
    REQ_BLK64_ERASE  = 3'd4,
    REQ_CHIP_ERASE   = 3'd5
  } req_t;

  // Framing actions on the output stream
  typedef enum logic [1:0] {
    ACT_SHIFT   = 2'd0,
    ACT_CS_HIGH = 2'd1,
    ACT_WAIT    = 2'd2
  } action_t;

  // Beat slots of one command, in the order they go out
  localparam int STEP_COUNT = 11;
  typedef enum logic [3:0] {
    STEP_CLOSE = 4'd0,   // deselect an open frame before an erase
    STEP_WAIT0 = 4'd1,
    STEP_WREN  = 4'd2,
    STEP_CS0   = 4'd3,
    STEP_OP    = 4'd4,
    STEP_A2    = 4'd5,
    STEP_A1    = 4'd6,
    STEP_A0    = 4'd7,
    STEP_BODY  = 4'd8,
    STEP_CS1   = 4'd9,
    STEP_WAIT1 = 4'd10
  } step_t;

  // Command descriptor handed from front to back
  typedef struct packed {
    logic [STEP_COUNT-1:0] mask;     // slots to emit
    logic [BYTE_W-1:0]     wren_op;
    logic [BYTE_W-1:0]     opcode;
    logic [ADDR_W-1:0]     addr;
    logic [BYTE_W-1:0]     data;
    logic                  capture;  // body is a captured dummy byte
  } desc_t;

endpackage

### rtl/core/spifcs_queue.sv
`timescale 1ns / 1ps

module spifcs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  spifcs_pkg::desc_t    push_desc,
  output logic                 full,
  input  logic                 pop,
  output spifcs_pkg::desc_t    head_desc,
  output logic                 head_valid
);
  import spifcs_pkg::*;

  desc_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_desc  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store descriptors
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/spifcs_front.sv
`timescale 1ns / 1ps

module spifcs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    req_type,
  input  logic [spifcs_pkg::ADDR_W-1:0] address,
  input  logic [spifcs_pkg::BYTE_W-1:0] data_byte,
  input  logic                          first_item,
  input  logic                          last_item,
  input  logic                          cfg_we,
  input  logic [spifcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spifcs_pkg::BYTE_W-1:0] cfg_data,
  output logic                          push,
  output spifcs_pkg::desc_t             push_desc,
  input  logic                          queue_full
);
  import spifcs_pkg::*;

  logic [BYTE_W-1:0] read_op;
  logic [BYTE_W-1:0] program_op;
  logic [BYTE_W-1:0] wren_op;
  logic [BYTE_W-1:0] sector_op;
  logic [BYTE_W-1:0] blk32_op;
  logic [BYTE_W-1:0] blk64_op;
  logic [BYTE_W-1:0] chip_op;

  logic              frame_open;
  logic              frame_open_next;
  logic [ADDR_W-1:0] running_address;
  logic [ADDR_W-1:0] running_address_next;

  logic              accept;
  logic              known;
  logic [ADDR_W-1:0] run_addr;
  logic [ADDR_W-1:0] run_addr_inc;
  logic              page_end;
  desc_t             desc;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && known;
  assign push_desc = desc;

  // Address of this run byte and of the one after it
  assign run_addr     = (!frame_open && first_item) ? address : running_address;
  assign run_addr_inc = run_addr + 1'b1;
  assign page_end     = ((run_addr_inc & PAGE_MASK) == '0);

  // Classify the item and build its command descriptor
  always_comb begin
    desc                 = '0;
    desc.wren_op         = wren_op;
    desc.data            = data_byte;
    desc.addr            = address;
    known                = 1'b1;
    frame_open_next      = frame_open;
    running_address_next = running_address;
    unique case (req_type)
      REQ_PROGRAM: begin
        desc.addr   = run_addr;
        desc.opcode = program_op;
        if (!frame_open) begin
          desc.mask[STEP_WAIT0] = 1'b1;
          desc.mask[STEP_WREN]  = 1'b1;
          desc.mask[STEP_CS0]   = 1'b1;
          desc.mask[STEP_OP]    = 1'b1;
          desc.mask[STEP_A2]    = 1'b1;
          desc.mask[STEP_A1]    = 1'b1;
          desc.mask[STEP_A0]    = 1'b1;
        end
        desc.mask[STEP_BODY] = 1'b1;
        if (last_item || page_end) begin
          desc.mask[STEP_CS1]   = 1'b1;
          desc.mask[STEP_WAIT1] = 1'b1;
          frame_open_next       = 1'b0;
        end else begin
          frame_open_next = 1'b1;
        end
        running_address_next = run_addr_inc;
      end
      REQ_READ: begin
        desc.addr    = run_addr;
        desc.opcode  = read_op;
        desc.capture = 1'b1;
        if (!frame_open) begin
          desc.mask[STEP_OP] = 1'b1;
          desc.mask[STEP_A2] = 1'b1;
          desc.mask[STEP_A1] = 1'b1;
          desc.mask[STEP_A0] = 1'b1;
        end
        desc.mask[STEP_BODY] = 1'b1;
        desc.mask[STEP_CS1]  = last_item;
        frame_open_next      = !last_item;
        running_address_next = run_addr_inc;
      end
      REQ_SECTOR_ERASE, REQ_BLK32_ERASE, REQ_BLK64_ERASE, REQ_CHIP_ERASE: begin
        unique case (req_type)
          REQ_SECTOR_ERASE: desc.opcode = sector_op;
          REQ_BLK32_ERASE:  desc.opcode = blk32_op;
          REQ_BLK64_ERASE:  desc.opcode = blk64_op;
          default:          desc.opcode = chip_op;
        endcase
        desc.mask[STEP_CLOSE] = frame_open;
        desc.mask[STEP_WAIT0] = 1'b1;
        desc.mask[STEP_WREN]  = 1'b1;
        desc.mask[STEP_CS0]   = 1'b1;
        desc.mask[STEP_OP]    = 1'b1;
        if (req_type != REQ_CHIP_ERASE) begin
          desc.mask[STEP_A2] = 1'b1;
          desc.mask[STEP_A1] = 1'b1;
          desc.mask[STEP_A0] = 1'b1;
        end
        desc.mask[STEP_CS1]   = 1'b1;
        desc.mask[STEP_WAIT1] = 1'b1;
        frame_open_next       = 1'b0;
      end
      default: begin
        // unused request codes: drop the item, keep the state
        known = 1'b0;
      end
    endcase
  end

  // Hold frame state across items
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      running_address <= '0;
    end else if (accept) begin
      frame_open      <= frame_open_next;
      running_address <= running_address_next;
    end
  end

  // Opcode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_op    <= 8'h03;
      program_op <= 8'h02;
      wren_op    <= 8'h06;
      sector_op  <= 8'h20;
      blk32_op   <= 8'h52;
      blk64_op   <= 8'hD8;
      chip_op    <= 8'hC7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_READ_OP:    read_op    <= cfg_data;
        CFG_PROGRAM_OP: program_op <= cfg_data;
        CFG_WREN_OP:    wren_op    <= cfg_data;
        CFG_SECTOR_OP:  sector_op  <= cfg_data;
        CFG_BLK32_OP:   blk32_op   <= cfg_data;
        CFG_BLK64_OP:   blk64_op   <= cfg_data;
        CFG_CHIP_OP:    chip_op    <= cfg_data;
        default:        ;
      endcase
    end
  end

endmodule

### rtl/core/spifcs_back.sv
`timescale 1ns / 1ps

module spifcs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  spifcs_pkg::desc_t             head_desc,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    action,
  output logic [spifcs_pkg::BYTE_W-1:0] spi_byte,
  output logic                          capture_read,
  output logic                          run_done
);
  import spifcs_pkg::*;

  desc_t                 cur;
  logic [STEP_COUNT-1:0] cur_mask;
  logic [STEP_COUNT-1:0] mask_rest;
  logic                  advance;
  logic                  last_beat;
  step_t                 step;
  action_t               beat_action;
  logic [BYTE_W-1:0]     beat_byte;
  logic                  beat_capture;

  // Pick the lowest pending slot
  always_comb begin
    step = STEP_CLOSE;
    for (int i = STEP_COUNT - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        step = step_t'(4'(i));
      end
    end
  end

  assign mask_rest = cur_mask & (cur_mask - 1'b1);
  assign last_beat = (mask_rest == '0);
  assign advance   = (cur_mask != '0) && (!out_valid || out_ready);
  assign pop       = head_valid && ((cur_mask == '0) || (advance && last_beat));

  // Decode the slot into a beat
  always_comb begin
    beat_action  = ACT_SHIFT;
    beat_byte    = '0;
    beat_capture = 1'b0;
    unique case (step)
      STEP_CLOSE: beat_action = ACT_CS_HIGH;
      STEP_WAIT0: beat_action = ACT_WAIT;
      STEP_WREN:  beat_byte   = cur.wren_op;
      STEP_CS0:   beat_action = ACT_CS_HIGH;
      STEP_OP:    beat_byte   = cur.opcode;
      STEP_A2:    beat_byte   = cur.addr[23:16];
      STEP_A1:    beat_byte   = cur.addr[15:8];
      STEP_A0:    beat_byte   = cur.addr[7:0];
      STEP_BODY: begin
        beat_byte    = cur.capture ? 8'h00 : cur.data;
        beat_capture = cur.capture;
      end
      STEP_CS1:   beat_action = ACT_CS_HIGH;
      STEP_WAIT1: beat_action = ACT_WAIT;
      default:    beat_action = ACT_SHIFT;
    endcase
  end

  // Load the next command and retire slots
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= '0;
    end else if (pop) begin
      cur_mask <= head_desc.mask;
    end else if (advance) begin
      cur_mask <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_desc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action       <= beat_action;
      spi_byte     <= beat_byte;
      capture_read <= beat_capture;
      run_done     <= last_beat;
    end
  end

endmodule

### rtl/core/spi_flash_command_sequencer_core.sv
`timescale 1ns / 1ps

// SPI NOR flash command sequencer. Each input beat is one byte of a read or
// program run, or one erase request; it is classified combinationally and
// turned into a command descriptor that waits in a four-entry queue. The back
// end expands each descriptor into 1 to 10 output beats (shift a byte, raise
// chip select, wait while busy), one beat per cycle while m_tready allows, the
// last one flagged in tlast. An input beat is taken every cycle while the queue
// has room, so the sustained rate is set by the number of output beats per
// item and by m_tready: as few as one output beat for a frame-continuing byte,
// up to ten at the start of a page segment or for an erase. Program runs close
// at every page boundary of PAGE_BYTES. Opcodes are to be written through the
// cfg port only while the block is idle; the block itself does not enforce it.
module spi_flash_command_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // address[23:0], data_byte[31:24], first_item[32], zero
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  input  logic        s_tlast,   // last_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // spi_byte[7:0]
  output logic [2:0]  m_tuser,   // action[1:0], capture_read[2]
  output logic        m_tlast,   // run_done
  input  logic        cfg_we,
  input  logic [spifcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);
  import spifcs_pkg::*;

  logic  push;
  desc_t push_desc;
  logic  queue_full;
  logic  pop;
  desc_t head_desc;
  logic  head_valid;
  logic  capture_read;
  logic [1:0] action;

  spifcs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .req_type   (s_tuser),
    .address    (s_tdata[23:0]),
    .data_byte  (s_tdata[31:24]),
    .first_item (s_tdata[32]),
    .last_item  (s_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_desc  (push_desc),
    .queue_full (queue_full)
  );

  spifcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (queue_full),
    .pop        (pop),
    .head_desc  (head_desc),
    .head_valid (head_valid)
  );

  spifcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_desc    (head_desc),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .action       (action),
    .spi_byte     (m_tdata),
    .capture_read (capture_read),
    .run_done     (m_tlast)
  );

  assign m_tuser = {capture_read, action};

endmodule

### rtl/core/spifcs_checker.sv
`timescale 1ns / 1ps

module spifcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import spifcs_pkg::*;

  // A stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Captured beats are dummy shift bytes
  a_capture: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ACT_SHIFT && m_tdata == 8'h00)
    else $error("capture flag on a non-dummy beat");

  // Framing beats carry no byte and never a reserved action
  a_framing: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != ACT_SHIFT |-> m_tdata == 8'h00
      && (m_tuser[1:0] == ACT_CS_HIGH || m_tuser[1:0] == ACT_WAIT))
    else $error("bad framing beat");

endmodule

bind spi_flash_command_sequencer_core spifcs_checker u_checker (.*);
